@@ hw/rtl/gbc_pkg.sv @@
// Shared constants, types and helpers of the grid broad-phase block.
// No dependencies; every other file but gbc_checker refers to it by scoped names.
package gbc_pkg;

  localparam int GRID_COLS    = 4;
  localparam int GRID_ROWS    = 4;
  localparam int BUCKET_DEPTH = 16;
  localparam int COORD_WIDTH  = 12;

  localparam int NUM_CELLS = GRID_COLS * GRID_ROWS;
  localparam int COL_W     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int ROW_W     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int CELL_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int SLOT_W    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int CNT_W     = $clog2(BUCKET_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_CELLS * BUCKET_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int EXT_W     = COORD_WIDTH + 1;
  localparam int ID_W      = 8;
  localparam int REG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W    = $clog2(EXT_W + 1);

  localparam logic [REG_W-1:0] RST_CELL_W = REG_W'(320);
  localparam logic [REG_W-1:0] RST_CELL_H = REG_W'(240);
  localparam logic [REG_W-1:0] RST_WRAP_W = REG_W'(1280);
  localparam logic [REG_W-1:0] RST_WRAP_H = REG_W'(960);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_INSERT = 2'd1,
    OP_CHECK_BOX = 2'd2,
    OP_CHECK_POINT = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_W = 2'd0,
    REG_CELL_H = 2'd1,
    REG_WRAP_W = 2'd2,
    REG_WRAP_H = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [ID_W-1:0]        object_id;
    logic [COORD_WIDTH-1:0] pos_x;
    logic [COORD_WIDTH-1:0] pos_y;
    logic [COORD_WIDTH-1:0] box_width;
    logic [COORD_WIDTH-1:0] box_height;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0]        id;
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    logic [COORD_WIDTH-1:0] w;
    logic [COORD_WIDTH-1:0] h;
  } entry_t;

  typedef struct packed {
    logic [REG_W-1:0] cell_w;
    logic [REG_W-1:0] cell_h;
    logic [REG_W-1:0] wrap_w;
    logic [REG_W-1:0] wrap_h;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [EXT_W-1:0] dividend;
    logic [REG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [EXT_W-1:0] quot;
    logic [REG_W-1:0] rem;
  } div_rsp_t;

  // A zero size register acts as one.
  function automatic logic [REG_W-1:0] nz(input logic [REG_W-1:0] v);
    return (v == '0) ? REG_W'(1) : v;
  endfunction

endpackage

@@ hw/rtl/gbc_channels.sv @@
// Valid/ready channel interfaces for requests and results.
// Field widths come from gbc_pkg.
interface gbc_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      opcode;
  logic [gbc_pkg::ID_W-1:0]        object_id;
  logic [gbc_pkg::COORD_WIDTH-1:0] pos_x;
  logic [gbc_pkg::COORD_WIDTH-1:0] pos_y;
  logic [gbc_pkg::COORD_WIDTH-1:0] box_width;
  logic [gbc_pkg::COORD_WIDTH-1:0] box_height;
  modport source (output valid, opcode, object_id, pos_x, pos_y, box_width, box_height,
                  input ready);
  modport sink (input valid, opcode, object_id, pos_x, pos_y, box_width, box_height,
                output ready);
endinterface

interface gbc_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic overflow;
  modport source (output valid, hit, overflow, input ready);
  modport sink (input valid, hit, overflow, output ready);
endinterface

@@ hw/rtl/gbc_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Uses gbc_pkg types; serves both the wrap modulo and the cell division.
module gbc_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  gbc_pkg::div_req_t req,
  output gbc_pkg::div_rsp_t rsp
);

  logic                                busy_r;
  logic                                done_r;
  logic [gbc_pkg::STEP_W-1:0]          step_r;
  logic [gbc_pkg::EXT_W-1:0]           q_r;
  logic [gbc_pkg::REG_W-1:0]           rem_r;
  logic [gbc_pkg::REG_W-1:0]           d_r;
  logic [gbc_pkg::REG_W:0]             trial;
  logic [gbc_pkg::REG_W:0]             diff;
  logic                                ge;

  assign trial = {rem_r, q_r[gbc_pkg::EXT_W-1]};
  assign ge    = trial >= {1'b0, d_r};
  assign diff  = trial - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == gbc_pkg::STEP_W'(gbc_pkg::EXT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.dividend;
      rem_r <= '0;
      d_r   <= req.divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[gbc_pkg::EXT_W-2:0], ge};
      rem_r <= ge ? diff[gbc_pkg::REG_W-1:0] : trial[gbc_pkg::REG_W-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r;

endmodule

@@ hw/rtl/gbc_ctrl.sv @@
// Sequencer: corner hashing through the shared divider, bucket fill counts,
// bucket entry memory, scan and overlap test. Depends on gbc_pkg.
module gbc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  gbc_pkg::item_t    item,
  input  gbc_pkg::cfg_t     cfg,
  output logic              idle,
  output gbc_pkg::div_req_t div_req,
  input  gbc_pkg::div_rsp_t div_rsp,
  output logic              res_valid,
  output logic              res_hit,
  output logic              res_ovf,
  input  logic              res_ready
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV_START, S_DIV_WAIT, S_CORNER, S_RD, S_CMP, S_RESP
  } state_t;

  state_t                          state_r;
  gbc_pkg::item_t                  item_r;
  logic [1:0]                      hk_r;
  logic                            ph_r;
  logic [1:0]                      ci_r;
  logic [gbc_pkg::SLOT_W-1:0]      slot_r;
  logic [gbc_pkg::REG_W-1:0]       modr_r;
  logic [gbc_pkg::COL_W-1:0]       col0_r, col1_r;
  logic [gbc_pkg::ROW_W-1:0]       row0_r, row1_r;
  logic [gbc_pkg::CNT_W-1:0]       cnt_r [gbc_pkg::NUM_CELLS];
  logic                            hit_r, ovf_r, valid_r;
  gbc_pkg::entry_t                 mem [gbc_pkg::MEM_DEPTH];
  gbc_pkg::entry_t                 rd_data_r;

  logic [gbc_pkg::EXT_W-1:0]       x_ext, y_ext, xr, yb, coord;
  logic [gbc_pkg::REG_W-1:0]       wrap_sel, cell_sel;
  logic [gbc_pkg::CELL_W-1:0]      cc [4];
  logic [3:0]                      active;
  logic [gbc_pkg::CELL_W-1:0]      cur_cell;
  logic [gbc_pkg::CNT_W-1:0]       cur_cnt;
  logic                            is_point, last_corner, last_hash;
  logic [gbc_pkg::ADDR_W-1:0]      addr;
  logic                            mem_we;
  gbc_pkg::entry_t                 wr_entry;
  logic [gbc_pkg::EXT_W-1:0]       ex_r, ey_b, l, r, t, bt;
  logic [gbc_pkg::EXT_W-1:0]       px, py;
  logic                            overlap, pt_hit, match;
  logic [gbc_pkg::COL_W-1:0]       col_q;
  logic [gbc_pkg::ROW_W-1:0]       row_q;

  assign is_point = item_r.opcode == gbc_pkg::OP_CHECK_POINT;
  assign x_ext = {1'b0, item_r.pos_x};
  assign y_ext = {1'b0, item_r.pos_y};
  assign xr    = x_ext + {1'b0, item_r.box_width};
  assign yb    = y_ext + {1'b0, item_r.box_height};

  // Hash order: x, y, right edge, bottom edge.
  always_comb begin
    unique case (hk_r)
      2'd0:    coord = x_ext;
      2'd1:    coord = y_ext;
      2'd2:    coord = xr;
      default: coord = yb;
    endcase
    wrap_sel = gbc_pkg::nz(hk_r[0] ? cfg.wrap_h : cfg.wrap_w);
    cell_sel = gbc_pkg::nz(hk_r[0] ? cfg.cell_h : cfg.cell_w);
  end

  assign div_req.start    = state_r == S_DIV_START;
  assign div_req.dividend = ph_r ? {1'b0, modr_r} : coord;
  assign div_req.divisor  = ph_r ? cell_sel : wrap_sel;

  // Saturate column and row at the grid edge.
  assign col_q = (div_rsp.quot > gbc_pkg::EXT_W'(gbc_pkg::GRID_COLS - 1)) ?
                 gbc_pkg::COL_W'(gbc_pkg::GRID_COLS - 1) : div_rsp.quot[gbc_pkg::COL_W-1:0];
  assign row_q = (div_rsp.quot > gbc_pkg::EXT_W'(gbc_pkg::GRID_ROWS - 1)) ?
                 gbc_pkg::ROW_W'(gbc_pkg::GRID_ROWS - 1) : div_rsp.quot[gbc_pkg::ROW_W-1:0];
  assign last_hash = is_point ? (hk_r == 2'd1) : (hk_r == 2'd3);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cc[i] = gbc_pkg::CELL_W'((i[1] ? row1_r : row0_r) * gbc_pkg::GRID_COLS
                               + (i[0] ? col1_r : col0_r));
    end
    active[0] = 1'b1;
    active[1] = cc[1] != cc[0];
    active[2] = (cc[2] != cc[0]) && (cc[2] != cc[1]);
    active[3] = (cc[3] != cc[0]) && (cc[3] != cc[1]) && (cc[3] != cc[2]);
  end

  assign cur_cell    = cc[ci_r];
  assign cur_cnt     = cnt_r[cur_cell];
  assign last_corner = is_point || (ci_r == 2'd3);
  assign addr = gbc_pkg::ADDR_W'(cur_cell * gbc_pkg::BUCKET_DEPTH)
              + gbc_pkg::ADDR_W'(mem_we ? cur_cnt[gbc_pkg::SLOT_W-1:0] : slot_r);
  assign mem_we = (state_r == S_CORNER) && (item_r.opcode == gbc_pkg::OP_INSERT)
                  && active[ci_r] && (cur_cnt < gbc_pkg::CNT_W'(gbc_pkg::BUCKET_DEPTH));
  assign wr_entry = '{id: item_r.object_id, x: item_r.pos_x, y: item_r.pos_y,
                      w: item_r.box_width, h: item_r.box_height};

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= wr_entry;
    if (state_r == S_RD) rd_data_r <= mem[addr];
  end

  // Half-open boxes, strict overlap.
  always_comb begin
    ex_r = {1'b0, rd_data_r.x} + {1'b0, rd_data_r.w};
    ey_b = {1'b0, rd_data_r.y} + {1'b0, rd_data_r.h};
    l  = (x_ext > {1'b0, rd_data_r.x}) ? x_ext : {1'b0, rd_data_r.x};
    r  = (xr < ex_r) ? xr : ex_r;
    t  = (y_ext > {1'b0, rd_data_r.y}) ? y_ext : {1'b0, rd_data_r.y};
    bt = (yb < ey_b) ? yb : ey_b;
    overlap = (l < r) && (t < bt);
    px = x_ext;
    py = y_ext;
    pt_hit = (px >= {1'b0, rd_data_r.x}) && (px < ex_r)
          && (py >= {1'b0, rd_data_r.y}) && (py < ey_b);
    match = is_point ? pt_hit : ((rd_data_r.id != item_r.object_id) && overlap);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
      ovf_r   <= 1'b0;
      hk_r    <= '0;
      ph_r    <= 1'b0;
      ci_r    <= '0;
      slot_r  <= '0;
      for (int i = 0; i < gbc_pkg::NUM_CELLS; i++) cnt_r[i] <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            item_r <= item;
            hit_r  <= 1'b0;
            ovf_r  <= 1'b0;
            hk_r   <= '0;
            ph_r   <= 1'b0;
            ci_r   <= '0;
            if (item.opcode == gbc_pkg::OP_CLEAR) begin
              for (int i = 0; i < gbc_pkg::NUM_CELLS; i++) cnt_r[i] <= '0;
              valid_r <= 1'b1;
              state_r <= S_RESP;
            end else begin
              state_r <= S_DIV_START;
            end
          end
        end
        S_DIV_START: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            if (!ph_r) begin
              modr_r  <= div_rsp.rem;
              ph_r    <= 1'b1;
              state_r <= S_DIV_START;
            end else begin
              unique case (hk_r)
                2'd0:    col0_r <= col_q;
                2'd1:    row0_r <= row_q;
                2'd2:    col1_r <= col_q;
                default: row1_r <= row_q;
              endcase
              ph_r <= 1'b0;
              hk_r <= hk_r + 2'd1;
              state_r <= last_hash ? S_CORNER : S_DIV_START;
            end
          end
        end
        S_CORNER: begin
          if (active[ci_r] && item_r.opcode == gbc_pkg::OP_INSERT) begin
            if (mem_we) cnt_r[cur_cell] <= cur_cnt + 1'b1;
            else        ovf_r <= 1'b1;
          end
          if (active[ci_r] && item_r.opcode != gbc_pkg::OP_INSERT && cur_cnt != '0) begin
            slot_r  <= '0;
            state_r <= S_RD;
          end else if (last_corner) begin
            valid_r <= 1'b1;
            state_r <= S_RESP;
          end else begin
            ci_r <= ci_r + 2'd1;
          end
        end
        S_RD: state_r <= S_CMP;
        S_CMP: begin
          if (match) begin
            hit_r   <= 1'b1;
            valid_r <= 1'b1;
            state_r <= S_RESP;
          end else if (gbc_pkg::CNT_W'(slot_r) + 1'b1 < cur_cnt) begin
            slot_r  <= slot_r + 1'b1;
            state_r <= S_RD;
          end else if (last_corner) begin
            valid_r <= 1'b1;
            state_r <= S_RESP;
          end else begin
            ci_r    <= ci_r + 2'd1;
            state_r <= S_CORNER;
          end
        end
        S_RESP: begin
          if (res_ready) begin
            valid_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign idle      = state_r == S_IDLE;
  assign res_valid = valid_r;
  assign res_hit   = hit_r;
  assign res_ovf   = ovf_r;

endmodule

@@ hw/rtl/grid_broadphase_collision.sv @@
// Grid broad-phase collision top level: channels, config registers,
// sequencer and shared divider. Depends on gbc_pkg, gbc_channels, gbc_ctrl, gbc_divider.
//
// Usage: requests enter on in_ch (opcode clear, insert, box check, point check),
// one result (hit, overflow) leaves on out_ch for every request. Four
// 12-bit size registers are written through cfg_we/cfg_index/cfg_wdata; the
// user must do so only while the block is idle; the block itself does not enforce it.
// A clear request empties every bucket and goes straight to the result. Other
// requests hash their corners on a single restoring divider, two divisions
// per coordinate: two coordinates for a point and four for a box. Insert then
// stores the item in each distinct corner bucket, flagging overflow when one
// is full. Checks read entries from the bucket memory, up to four buckets of
// 16 entries for a box and one for a point, and stop at the first hit.
// in_ch.ready is high only while no request is in flight; the result is held
// in out_ch until taken, so a stalled receiver simply holds the block.
// Reset restores the default cell and wrap sizes and empties every bucket;
// no clearing pass is needed.
module grid_broadphase_collision (
  input  logic                          clk,
  input  logic                          rst_n,
  gbc_in_if.sink                        in_ch,
  gbc_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [gbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbc_pkg::REG_W-1:0]     cfg_wdata
);

  gbc_pkg::cfg_t     cfg_r;
  gbc_pkg::item_t    item;
  gbc_pkg::div_req_t div_req;
  gbc_pkg::div_rsp_t div_rsp;
  logic              idle;
  logic              start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cell_w <= gbc_pkg::RST_CELL_W;
      cfg_r.cell_h <= gbc_pkg::RST_CELL_H;
      cfg_r.wrap_w <= gbc_pkg::RST_WRAP_W;
      cfg_r.wrap_h <= gbc_pkg::RST_WRAP_H;
    end else if (cfg_we) begin
      unique case (gbc_pkg::reg_idx_t'(cfg_index))
        gbc_pkg::REG_CELL_W: cfg_r.cell_w <= cfg_wdata;
        gbc_pkg::REG_CELL_H: cfg_r.cell_h <= cfg_wdata;
        gbc_pkg::REG_WRAP_W: cfg_r.wrap_w <= cfg_wdata;
        gbc_pkg::REG_WRAP_H: cfg_r.wrap_h <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign item = '{opcode: in_ch.opcode, object_id: in_ch.object_id,
                  pos_x: in_ch.pos_x, pos_y: in_ch.pos_y,
                  box_width: in_ch.box_width, box_height: in_ch.box_height};
  assign in_ch.ready = idle;
  assign start = in_ch.valid && idle;

  gbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .item      (item),
    .cfg       (cfg_r),
    .idle      (idle),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .res_valid (out_ch.valid),
    .res_hit   (out_ch.hit),
    .res_ovf   (out_ch.overflow),
    .res_ready (out_ch.ready)
  );

  gbc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

@@ hw/rtl/gbc_checker.sv @@
// Port-level checks for grid_broadphase_collision, attached by bind.
// Depends only on the top level's ports.
module gbc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit,
  input logic out_overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request taken while result pending");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after request");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("more than one result per request");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_overflow))
    else $error("hit and overflow both set");

endmodule

bind grid_broadphase_collision gbc_checker u_gbc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_hit      (out_ch.hit),
  .out_overflow (out_ch.overflow)
);
